FILE: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCD_ASSERT_IMP(lbl, ante, cons, msg)
`define TCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/tcd_pkg.sv
// Shared constants, codes and types of the tuning command deframer.
// No dependencies.
package tcd_pkg;

    localparam int WORD_COUNT  = 14;
    localparam int PAYLOAD_LEN = 4 * WORD_COUNT;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN + 1);
    localparam int IDX_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(WORD_COUNT - 1);
    localparam logic [CNT_W-1:0] PAYLOAD_END = CNT_W'(PAYLOAD_LEN);

    // framing bytes
    localparam logic [7:0] HDR_FIRST  = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] TAIL_OK    = 8'h02;

    // command codes
    localparam logic [7:0] CMD_READ    = 8'd1;
    localparam logic [7:0] CMD_CAPTURE = 8'd2;
    localparam logic [7:0] CMD_PAGE    = 8'd4;
    localparam logic [7:0] CMD_SEND    = 8'd5;
    localparam logic [7:0] CMD_SW3     = 8'd6;
    localparam logic [7:0] CMD_SW4     = 8'd7;

    // event kinds
    localparam logic [2:0] EV_WORD    = 3'd0;
    localparam logic [2:0] EV_READ    = 3'd1;
    localparam logic [2:0] EV_CAPTURE = 3'd2;
    localparam logic [2:0] EV_PAGE    = 3'd3;
    localparam logic [2:0] EV_SEND    = 3'd4;
    localparam logic [2:0] EV_SW3     = 3'd5;
    localparam logic [2:0] EV_SW4     = 3'd6;

    localparam logic [1:0] PAGE_TOP = 2'd3;
    localparam logic [1:0] SEND_TOP = 2'd2;

    // one unit of work for the back end
    typedef struct packed {
        logic       dump;       // emit the captured words first
        logic       cmd_valid;  // then one command event
        logic [2:0] cmd_kind;
        logic [1:0] page_old;
        logic [1:0] send_old;
        logic [1:0] page_new;
        logic [1:0] send_new;
    } job_t;

    // payload byte write into the word store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [1:0]       lane;
        logic [7:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic dumping;
        logic words_done;
    } back_stat_t;

endpackage

FILE: rtl/tcd_front.sv
// Front end: takes input bytes, tracks header/capture/page state, writes payload.
// Depends on tcd_pkg.
module tcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    output tcd_pkg::job_t       job,
    output logic                push,
    input  logic                q_full,
    output tcd_pkg::mem_wr_t    mem_wr,
    input  tcd_pkg::back_stat_t back_stat
);
    import tcd_pkg::*;

    logic [7:0]       prev_reg, prev_next;
    logic [7:0]       prev2_reg, prev2_next;
    logic             capturing_reg, capturing_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       page_reg, page_next;
    logic [1:0]       send_reg, send_next;
    logic             busy_reg, busy_next;   // words of a frame not yet drained

    logic will_write;
    logic acc;
    logic hdr;
    logic dump;
    logic cmd_valid;
    logic [2:0] cmd_kind;

    assign will_write = capturing_reg && (count_reg < PAYLOAD_END);
    assign s_tready   = !q_full && !(will_write && busy_reg);
    assign acc        = s_tvalid && s_tready;
    assign hdr        = (prev2_reg == HDR_FIRST) && (prev_reg == HDR_SECOND);

    always_comb
    begin
        prev_next      = prev_reg;
        prev2_next     = prev2_reg;
        capturing_next = capturing_reg;
        count_next     = count_reg;
        page_next      = page_reg;
        send_next      = send_reg;
        dump           = 1'b0;
        cmd_valid      = 1'b0;
        cmd_kind       = EV_READ;
        if (acc)
        begin
            if (capturing_reg)
            begin
                if (will_write)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    count_next     = '0;
                    capturing_next = 1'b0;
                    dump           = (s_tdata == TAIL_OK);
                end
            end
            if (hdr)
            begin
                unique case (s_tdata)
                    CMD_READ:
                    begin
                        cmd_valid = 1'b1;
                        cmd_kind  = EV_READ;
                    end
                    CMD_CAPTURE:
                    begin
                        cmd_valid      = 1'b1;
                        cmd_kind       = EV_CAPTURE;
                        capturing_next = 1'b1;
                        count_next     = '0;
                    end
                    CMD_PAGE:
                    begin
                        cmd_valid = 1'b1;
                        cmd_kind  = EV_PAGE;
                        page_next = (page_reg >= PAGE_TOP) ? 2'd1 : page_reg + 2'd1;
                    end
                    CMD_SEND:
                    begin
                        cmd_valid = 1'b1;
                        cmd_kind  = EV_SEND;
                        send_next = (send_reg >= SEND_TOP) ? 2'd1 : send_reg + 2'd1;
                    end
                    CMD_SW3:
                    begin
                        cmd_valid = 1'b1;
                        cmd_kind  = EV_SW3;
                    end
                    CMD_SW4:
                    begin
                        cmd_valid = 1'b1;
                        cmd_kind  = EV_SW4;
                    end
                    default:
                    begin
                        cmd_valid = 1'b0;
                    end
                endcase
            end
            prev2_next = prev_reg;
            prev_next  = s_tdata;
        end
    end

    assign push = acc && (dump || cmd_valid);

    always_comb
    begin
        job.dump      = dump;
        job.cmd_valid = cmd_valid;
        job.cmd_kind  = cmd_kind;
        job.page_old  = page_reg;
        job.send_old  = send_reg;
        job.page_new  = page_next;
        job.send_new  = send_next;
    end

    always_comb
    begin
        mem_wr.en   = acc && will_write;
        mem_wr.addr = count_reg[IDX_W+1:2];
        mem_wr.lane = count_reg[1:0];
        mem_wr.data = s_tdata;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (push && dump)
        begin
            busy_next = 1'b1;
        end
        else if (back_stat.words_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            prev2_reg     <= '0;
            capturing_reg <= 1'b0;
            count_reg     <= '0;
            page_reg      <= 2'd1;
            send_reg      <= 2'd1;
            busy_reg      <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            prev2_reg     <= prev2_next;
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
            page_reg      <= page_next;
            send_reg      <= send_next;
            busy_reg      <= busy_next;
        end
    end

endmodule

FILE: rtl/tcd_queue.sv
// Two-entry job queue between front and back end.
// Depends on tcd_pkg.
module tcd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcd_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output tcd_pkg::job_t head,
    output logic          head_valid
);
    import tcd_pkg::*;

    job_t       entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/tcd_back.sv
// Back end: word store, word readout sequencer and output register.
// Depends on tcd_pkg.
module tcd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tcd_pkg::job_t       head,
    input  logic                head_valid,
    output logic                pop,
    input  tcd_pkg::mem_wr_t    mem_wr,
    output tcd_pkg::back_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import tcd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_HOLD  = 2'd2;

    logic [31:0] mem [WORD_COUNT];
    logic [31:0] rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             cmd_phase_reg, cmd_phase_next;
    logic             valid_reg, valid_next;
    logic [2:0]       kind_reg;
    logic [3:0]       oidx_reg;
    logic [31:0]      value_reg;
    logic [1:0]       opage_reg;
    logic [1:0]       osend_reg;
    logic             olast_reg;

    logic             load_word;
    logic             load_cmd;
    logic [IDX_W-1:0] word_sel;
    logic [IDX_W-1:0] idx_inc;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             words_done;
    logic             out_take;

    assign idx_inc  = idx_reg + 1'b1;
    assign out_take = valid_reg && m_tready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_phase_next = cmd_phase_reg;
        valid_next     = valid_reg;
        load_word      = 1'b0;
        load_cmd       = 1'b0;
        word_sel       = idx_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        pop            = 1'b0;
        words_done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.dump)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        load_cmd       = 1'b1;
                        pop            = 1'b1;
                        cmd_phase_next = 1'b1;
                        state_next     = ST_HOLD;
                    end
                end
            end
            ST_FETCH:
            begin
                load_word      = 1'b1;
                cmd_phase_next = 1'b0;
                state_next     = ST_HOLD;
                // prefetch the following word
                if (idx_reg != LAST_IDX)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc;
                end
            end
            ST_HOLD:
            begin
                if (out_take)
                begin
                    if (cmd_phase_reg)
                    begin
                        valid_next     = 1'b0;
                        cmd_phase_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else if (idx_reg != LAST_IDX)
                    begin
                        idx_next  = idx_inc;
                        load_word = 1'b1;
                        word_sel  = idx_inc;
                        if (idx_inc != LAST_IDX)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = idx_inc + 1'b1;
                        end
                    end
                    else
                    begin
                        words_done = 1'b1;
                        pop        = 1'b1;
                        if (head.cmd_valid)
                        begin
                            load_cmd       = 1'b1;
                            cmd_phase_next = 1'b1;
                        end
                        else
                        begin
                            valid_next = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_word || load_cmd)
        begin
            valid_next = 1'b1;
        end
    end

    always_comb
    begin
        stat.dumping    = (state_reg != ST_IDLE) && !cmd_phase_reg;
        stat.words_done = words_done;
    end

    // byte-lane write, one word read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr][{mem_wr.lane, 3'b000} +: 8] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            kind_reg  <= EV_WORD;
            oidx_reg  <= 4'(word_sel);
            value_reg <= rd_data_reg;
            opage_reg <= head.page_old;
            osend_reg <= head.send_old;
            olast_reg <= (word_sel == LAST_IDX) && !head.cmd_valid;
        end
        else if (load_cmd)
        begin
            kind_reg  <= head.cmd_kind;
            oidx_reg  <= '0;
            value_reg <= '0;
            opage_reg <= head.page_new;
            osend_reg <= head.send_new;
            olast_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cmd_phase_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cmd_phase_reg <= cmd_phase_next;
            valid_reg     <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {osend_reg, opage_reg, value_reg, oidx_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = olast_reg;

endmodule

FILE: rtl/tuning_command_deframer_core.sv
// Top level of the tuning command deframer: front end, job queue, back end.
// Depends on tcd_pkg, tcd_front, tcd_queue, tcd_back and assert_macros.svh.
`include "assert_macros.svh"

// Received serial bytes enter on the s_ stream, one byte per request. Any byte
// that follows 0x55 0xAA is a command: 1 read request, 2 capture start, 4 page
// step (1..3), 5 send mode step (1..2), 6/7 switch events; other codes do
// nothing. After a capture start the next 56 bytes are stored and the byte
// after them is the tail: a tail of 2 emits 14 little-endian 32-bit words
// (index 0..13), a bad tail drops the frame. Header detection keeps running
// during capture, so a tail byte may also start the next capture; its words
// come out first, then the command event. m_tlast marks the last result
// caused by one input byte. Timing: a byte is normally taken every cycle.
// A good tail starts the word store read, then the words go out at one word
// per cycle while the output is not stalled. A two-entry job queue decouples
// byte intake from result output; intake stalls only when the queue is full,
// or when a payload byte of a new capture arrives while the previous frame's
// words are still being read out (the word store has a single write and a
// single read port). No clearing pass after reset.
module tuning_command_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] word_index, [35:4] word_value,
                                   // [37:36] page_now, [39:38] send_mode_now
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast    // last_word
);
    import tcd_pkg::*;

    job_t       push_job;
    job_t       head_job;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       head_valid;
    mem_wr_t    mem_wr;
    back_stat_t back_stat;

    tcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job       (push_job),
        .push      (q_push),
        .q_full    (q_full),
        .mem_wr    (mem_wr),
        .back_stat (back_stat)
    );

    tcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .wr_job     (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head_job),
        .head_valid (head_valid)
    );

    tcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .head_valid (head_valid),
        .pop        (q_pop),
        .mem_wr     (mem_wr),
        .stat       (back_stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // payload writes never overlap a word readout
    `TCD_ASSERT_IMP(a_no_wr_during_dump, mem_wr.en, !back_stat.dumping, "payload write during readout")
    // front never pushes into a full queue
    `TCD_ASSERT_IMP(a_no_q_overflow, q_push, !q_full, "job queue overflow")
    // readout finishes on the last word going out
    `TCD_ASSERT_IMP(a_done_on_last, back_stat.words_done, m_tvalid && m_tready && (m_tuser == EV_WORD) && (m_tdata[3:0] == 4'(LAST_IDX)), "readout end mismatch")
    // after the last word the back end leaves the readout
    `TCD_ASSERT_NXT(a_done_exits, back_stat.words_done, !back_stat.dumping, "readout did not end")

endmodule

FILE: sim/tb.sv
// Self-checking testbench of tuning_command_deframer_core: byte stream in, event stream out.
// Depends on tcd_pkg and the RTL of the deframer; everything else is local to this file.
module tb;
    import tcd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;  // generous
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 40;      // extra idle time after the results have drained
    localparam int REPORT_MAX   = 10;

    // One result as the block reports it.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  idx;
        logic [31:0] value;
        logic [1:0]  page;
        logic [1:0]  send;
        logic        last;
    } deframe_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // steady = 1 turns off idling on both sides
    bit steady = 1'b0;

    int cycle_count  = 0;
    int sent_count   = 0;
    int noise_count  = 0;
    int result_count = 0;
    int fail_count   = 0;
    int good_frames  = 0;
    int bad_frames   = 0;

    // Shadow copy of the deframer state
    logic [7:0] last_rx;
    logic [7:0] last_rx2;
    logic       cap_active;
    int         cap_count;
    logic [7:0] payload_copy [PAYLOAD_LEN];
    logic [1:0] cur_page;
    logic [1:0] cur_send_mode;

    deframe_result_t expected_results[$];

    // Payload of the next frame to send
    logic [7:0] frame_buf [PAYLOAD_LEN];

    tuning_command_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver back-pressure: m_tready is low about 15 percent of the time
    always @(posedge clk)
    begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("[tuning_command_deframer_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic deframe_result_t make_event(input logic [2:0] kind,
                                                   input logic [3:0] idx,
                                                   input logic [31:0] value);
        deframe_result_t ev;
        ev.kind  = kind;
        ev.idx   = idx;
        ev.value = value;
        ev.page  = cur_page;
        ev.send  = cur_send_mode;
        ev.last  = 1'b0;
        return ev;
    endfunction

    function automatic void reset_shadow();
        last_rx       = 8'h00;
        last_rx2      = 8'h00;
        cap_active    = 1'b0;
        cap_count     = 0;
        cur_page      = 2'd1;
        cur_send_mode = 2'd1;
        foreach (payload_copy[i])
            payload_copy[i] = 8'h00;
    endfunction

    // Everything one received byte causes, in the block's order:
    // capture handling, then the header check, then the history shift.
    function automatic void deframe_byte(input logic [7:0] b);
        deframe_result_t burst[$];
        deframe_result_t ev;
        logic [31:0]     word;
        if (cap_active)
        begin
            if (cap_count < PAYLOAD_LEN)
            begin
                payload_copy[cap_count] = b;
                cap_count++;
            end
            else
            begin
                // tail byte: good tail dumps the words, anything else drops
                cap_count  = 0;
                cap_active = 1'b0;
                if (b == TAIL_OK)
                begin
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        word = {payload_copy[4*i+3], payload_copy[4*i+2],
                                payload_copy[4*i+1], payload_copy[4*i]};
                        burst.push_back(make_event(EV_WORD, 4'(i), word));
                    end
                end
            end
        end
        if (last_rx2 == HDR_FIRST && last_rx == HDR_SECOND)
        begin
            case (b)
                CMD_READ:
                    burst.push_back(make_event(EV_READ, '0, '0));
                CMD_CAPTURE:
                begin
                    // also restarts a capture already running
                    cap_active = 1'b1;
                    cap_count  = 0;
                    burst.push_back(make_event(EV_CAPTURE, '0, '0));
                end
                CMD_PAGE:
                begin
                    cur_page = (cur_page >= PAGE_TOP) ? 2'd1 : cur_page + 2'd1;
                    burst.push_back(make_event(EV_PAGE, '0, '0));
                end
                CMD_SEND:
                begin
                    cur_send_mode = (cur_send_mode >= SEND_TOP) ? 2'd1
                                                                : cur_send_mode + 2'd1;
                    burst.push_back(make_event(EV_SEND, '0, '0));
                end
                CMD_SW3:
                    burst.push_back(make_event(EV_SW3, '0, '0));
                CMD_SW4:
                    burst.push_back(make_event(EV_SW4, '0, '0));
                default:
                    ;   // unknown codes are ignored
            endcase
        end
        last_rx2 = last_rx;
        last_rx  = b;
        if (burst.size() > 0)
        begin
            ev = burst.pop_back();
            ev.last = 1'b1;
            burst.push_back(ev);
        end
        foreach (burst[i])
            expected_results.push_back(burst[i]);
    endfunction

    function automatic void report_mismatch(input string what, input deframe_result_t want,
                                            input deframe_result_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("%s at cycle %0d:", what, cycle_count);
            $display("  expected kind %0d idx %0d value %h page %0d send %0d last %0b",
                     want.kind, want.idx, want.value, want.page, want.send, want.last);
            $display("  got      kind %0d idx %0d value %h page %0d send %0d last %0b",
                     got.kind, got.idx, got.value, got.page, got.send, got.last);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted byte, check each accepted result.
    // Both sampled at the clock edge, before any NBA of this step lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        deframe_result_t got;
        deframe_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.kind  = m_tuser;
                got.idx   = m_tdata[3:0];
                got.value = m_tdata[35:4];
                got.page  = m_tdata[37:36];
                got.send  = m_tdata[39:38];
                got.last  = m_tlast;
                result_count++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // One request on the slave side. s_tvalid stays high after acceptance
    // so back-to-back bytes never lower and raise it in the same step.
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 15);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    // Sender holds off until every predicted result has come out.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        // let the byte accepted last be predicted before checking the queue
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_header(input logic [7:0] cmd);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(cmd);
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones, 3 random with an embedded header and a command or ignored code
    task automatic fill_payload(input int fill);
        int p;
        foreach (frame_buf[i])
            case (fill)
                1:       frame_buf[i] = 8'h00;
                2:       frame_buf[i] = 8'hFF;
                default: frame_buf[i] = 8'($urandom);
            endcase
        if (fill == 3)
        begin
            p = $urandom_range(PAYLOAD_LEN - 3);
            frame_buf[p]   = HDR_FIRST;
            frame_buf[p+1] = HDR_SECOND;
            case ($urandom_range(5))
                0:       frame_buf[p+2] = CMD_READ;
                1:       frame_buf[p+2] = CMD_PAGE;
                2:       frame_buf[p+2] = CMD_SEND;
                3:       frame_buf[p+2] = CMD_SW3;
                4:       frame_buf[p+2] = CMD_SW4;
                default: frame_buf[p+2] = 8'd3;   // not a command
            endcase
        end
    endtask

    // Payload body plus tail, header already sent
    task automatic send_capture(input logic [7:0] tail);
        foreach (frame_buf[i])
            send_byte(frame_buf[i]);
        send_byte(tail);
        if (tail == TAIL_OK)
            good_frames++;
        else
            bad_frames++;
    endtask

    function automatic logic [7:0] bad_tail();
        logic [7:0] t;
        do
            t = 8'($urandom);
        while (t == TAIL_OK);
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every command code except capture, two ignored codes, byte extremes and a false header
    task automatic test_commands();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(CMD_READ);
        send_header(8'd3);
        send_header(CMD_PAGE);
        send_header(CMD_SEND);
        send_header(CMD_SW3);
        send_header(CMD_SW4);
        send_header(8'hFF);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        wait_results_drained();
    endtask

    // Frame corner cases: extreme payloads, tail that is also a command,
    // bad tail, capture restarted from inside the payload
    task automatic test_frame_cases();
        // all-ones payload whose last two bytes form a header; the good
        // tail dumps the words and then starts the next capture
        send_header(CMD_CAPTURE);
        fill_payload(2);
        frame_buf[PAYLOAD_LEN-2] = HDR_FIRST;
        frame_buf[PAYLOAD_LEN-1] = HDR_SECOND;
        send_capture(TAIL_OK);
        // body of the capture just started: all zeros
        fill_payload(1);
        send_capture(TAIL_OK);
        // bad tail drops the frame; payload carries an embedded header of its own
        send_header(CMD_CAPTURE);
        fill_payload(3);
        send_capture(bad_tail());
        // capture start inside a payload: count restarts after the 0x02
        send_header(CMD_CAPTURE);
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom_range(8'h54)));
        send_header(CMD_CAPTURE);
        fill_payload(0);
        send_capture(TAIL_OK);
        wait_results_drained();
    endtask

    // A long stretch with neither side idling
    task automatic test_steady_burst();
        steady = 1'b1;
        send_header(CMD_CAPTURE);
        fill_payload(0);
        send_capture(TAIL_OK);
        send_header(CMD_PAGE);
        send_header(CMD_SEND);
        steady = 1'b0;
    endtask

    // Mostly well-formed commands and frames with random content, some noise
    task automatic test_random_traffic();
        int pick;
        int start;
        bit paused;
        start  = sent_count;
        paused = 1'b0;
        while (sent_count - noise_count - start < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                case ($urandom_range(7))
                    0:       send_header(CMD_READ);
                    1:       send_header(CMD_PAGE);
                    2:       send_header(CMD_SEND);
                    3:       send_header(CMD_SW3);
                    4:       send_header(CMD_SW4);
                    5:       send_header(8'd3);
                    6:       send_header(8'd0);
                    default: send_header(8'($urandom));
                endcase
            end
            else if (pick < 80)
            begin
                send_header(CMD_CAPTURE);
                case ($urandom_range(9))
                    0:       fill_payload(1);
                    1:       fill_payload(2);
                    2, 3, 4: fill_payload(3);
                    default: fill_payload(0);
                endcase
                send_capture(($urandom_range(99) < 80) ? TAIL_OK : bad_tail());
            end
            else
            begin
                // noise, including a half header now and then
                if ($urandom_range(3) == 0)
                begin
                    send_byte(HDR_FIRST);
                    noise_count++;
                end
                for (int i = $urandom_range(1, 4); i > 0; i--)
                begin
                    send_byte(8'($urandom));
                    noise_count++;
                end
            end
            // once, midway, hold the sender until the output side is empty
            if (!paused && sent_count - start > RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_results_drained();
            end
        end
    endtask

    initial
    begin
        reset_shadow();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_commands();
        test_frame_cases();
        test_steady_burst();
        test_random_traffic();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes (%0d noise), %0d frames with good tail, %0d dropped",
                 sent_count, noise_count, good_frames, bad_frames);
        $display("checked %0d results, %0d mismatches, %0d left waiting",
                 result_count, fail_count, expected_results.size());
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[tuning_command_deframer_core] OK");
        else
            $display("[tuning_command_deframer_core] ERROR");
        $finish;
    end

endmodule
